// File: rtl/core/cdt_pkg.sv
// Shared types and constants for the command debounce table.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package cdt_pkg;

    localparam int SLOTS_DEF    = 24;
    localparam int KEY_BITS_DEF = 32;

    localparam int ENTITY_KEY_W = 32;
    localparam int TIME_W       = 48;
    localparam int WINDOW_W     = 16;
    localparam int SLOT_IDX_W   = 6;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd250;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index carried in paddr above the byte offset.
    localparam logic [APB_ADDR_W-3:0] REG_WINDOW = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_WRITE,
        ST_DONE
    } cdt_state_t;

    typedef struct packed {
        logic idle;
        logic scan;
        logic check;
        logic write;
        logic emit;
    } cdt_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_key_valid;
        logic hit_now;
        logic scan_last;
        logic drop;
        logic out_free;
    } cdt_stat_t;

endpackage

// File: rtl/core/cdt_if.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on cdt_pkg for field widths.
interface cdt_cmd_if import cdt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    key_valid;
    logic [ENTITY_KEY_W-1:0] entity_key;
    logic [TIME_W-1:0]       now_ms;
    logic                    tgt_known;
    logic                    tgt_on;

    modport source (
        output valid, key_valid, entity_key, now_ms, tgt_known, tgt_on,
        input  ready
    );
    modport sink (
        input  valid, key_valid, entity_key, now_ms, tgt_known, tgt_on,
        output ready
    );
endinterface

interface cdt_res_if import cdt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  allow;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;

    modport source (
        output valid, allow, hit, slot_index,
        input  ready
    );
    modport sink (
        input  valid, allow, hit, slot_index,
        output ready
    );
endinterface

// File: rtl/core/command_debounce_table_core.sv
// Top level of the command debounce table: window register on the APB port,
// controller and datapath. Depends on cdt_pkg, cdt_if, cdt_ctrl and cdt_dp.
//
//  Port group | Role   | Beat contents
//  -----------+--------+--------------------------------------------------------
//  cmd        | sink   | key_valid, entity_key, now_ms, tgt_known, tgt_on
//  rsp        | source | allow, hit, slot_index
//  APB        | slave  | window_ms at byte address 0
//
// A command with a key is scanned sequentially through the slot memory's single read
// port, stopping at the hit slot or scanning all SLOTS slots on a miss; a dropped
// hit skips the write-back, and a command without a key goes straight to its result.
// Reset clears the used bits in flip-flops at once, so no clearing pass is needed. A
// new command is taken while a finished result is still held in the output register;
// a stalled result holds the sequencer only at its final step.
module command_debounce_table_core import cdt_pkg::*; #(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cdt_cmd_if.sink               cmd,
    cdt_res_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [WINDOW_W-1:0] window_reg;
    logic                sel_window;
    cdt_cmd_t            ctl_cmd;
    cdt_stat_t           ctl_st;

    assign pready     = 1'b1;
    assign sel_window = (paddr[APB_ADDR_W-1:2] == REG_WINDOW);
    assign prdata     = sel_window ? APB_DATA_W'(window_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel & penable & pwrite & pready & sel_window)
        begin
            window_reg <= pwdata[WINDOW_W-1:0];
        end
    end

    cdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (ctl_st),
        .cmd   (ctl_cmd)
    );

    cdt_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ctl_cmd),
        .st     (ctl_st),
        .window (window_reg),
        .in_ch  (cmd),
        .out_ch (rsp)
    );

endmodule

// File: rtl/core/cdt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cdt_ctrl.sv
// Sequencer for the debounce table: accept, slot scan, age check, write-back, result.
// Depends on cdt_pkg for the state type and the command/status structs.
module cdt_ctrl import cdt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cdt_stat_t st,
    output cdt_cmd_t  cmd
);

    cdt_state_t state_reg;
    cdt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (st.in_valid)
                begin
                    // A beat without a key goes straight to its all-zero result.
                    state_next = st.in_key_valid ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (st.hit_now)
                begin
                    state_next = ST_CHECK;
                end
                else if (st.scan_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_CHECK:
            begin
                state_next = st.drop ? ST_DONE : ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:  cmd.idle  = 1'b1;
            ST_SCAN:  cmd.scan  = 1'b1;
            ST_CHECK: cmd.check = 1'b1;
            ST_WRITE: cmd.write = 1'b1;
            ST_DONE:  cmd.emit  = st.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// File: rtl/core/cdt_dp.sv
// Datapath of the debounce table: slot memory, used bits, scan trackers,
// age check and the output register. Depends on cdt_pkg, cdt_if and cdt_ram.
module cdt_dp import cdt_pkg::*; #(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cdt_cmd_t            cmd,
    output cdt_stat_t           st,
    input  logic [WINDOW_W-1:0] window,
    cdt_cmd_if.sink             in_ch,
    cdt_res_if.source           out_ch
);

    localparam int KW = (KEY_BITS < ENTITY_KEY_W) ? KEY_BITS : ENTITY_KEY_W;
    localparam int MW = KW + TIME_W + 2;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // Item registers.
    logic [KW-1:0]     key_reg;
    logic [TIME_W-1:0] now_reg;
    logic              known_reg;
    logic              on_reg;

    // Scan state.
    logic [CW-1:0]     issue_reg;
    logic              eval_vld_reg;
    logic [IW-1:0]     eval_idx_reg;
    logic              have_free_reg;
    logic [IW-1:0]     free_idx_reg;
    logic              have_old_reg;
    logic [TIME_W-1:0] old_time_reg;
    logic [IW-1:0]     old_idx_reg;
    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [TIME_W-1:0] hit_time_reg;
    logic              hit_known_reg;
    logic              hit_on_reg;

    logic [SLOTS-1:0]  used_reg;

    logic              res_allow_reg;
    logic              res_hit_reg;
    logic [IW-1:0]     res_idx_reg;

    logic                  out_vld_reg;
    logic                  out_allow_reg;
    logic                  out_hit_reg;
    logic [SLOT_IDX_W-1:0] out_idx_reg;

    logic              accept;
    logic              rd_en;
    logic [MW-1:0]     rd_data;
    logic [KW-1:0]     rd_key;
    logic [TIME_W-1:0] rd_time;
    logic              rd_known;
    logic              rd_on;
    logic              ev;
    logic              ev_used;
    logic              ev_match;
    logic [IW-1:0]     wr_addr;
    logic [MW-1:0]     wr_data;
    logic [TIME_W:0]   age;
    logic              young;
    logic              dup;
    logic              out_free;

    assign accept = cmd.idle & in_ch.valid;
    assign in_ch.ready = cmd.idle;

    assign rd_en   = cmd.scan & (issue_reg < CW'(SLOTS));
    assign rd_key  = rd_data[MW-1 -: KW];
    assign rd_time = rd_data[TIME_W+1:2];
    assign rd_known = rd_data[1];
    assign rd_on    = rd_data[0];

    assign wr_addr = hit_reg ? hit_idx_reg : (have_free_reg ? free_idx_reg : old_idx_reg);
    assign wr_data = {key_reg, now_reg, known_reg, on_reg};

    cdt_ram #(
        .WIDTH (MW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (issue_reg[IW-1:0]),
        .rdata (rd_data)
    );

    // The read issued in the previous cycle is evaluated here.
    assign ev       = cmd.scan & eval_vld_reg;
    assign ev_used  = used_reg[eval_idx_reg];
    assign ev_match = ev & ev_used & (rd_key == key_reg);

    // A stored stamp later than now gives a borrow, which counts as young.
    assign age   = {1'b0, now_reg} - {1'b0, hit_time_reg};
    assign young = age[TIME_W] | (age[TIME_W-1:0] < TIME_W'(window));
    assign dup   = known_reg & hit_known_reg & (hit_on_reg == on_reg);

    assign out_free = ~out_vld_reg | out_ch.ready;

    always_comb
    begin
        st              = '0;
        st.in_valid     = in_ch.valid;
        st.in_key_valid = in_ch.key_valid;
        st.hit_now      = ev_match;
        st.scan_last    = ev & (eval_idx_reg == IW'(SLOTS - 1));
        st.drop         = dup & young;
        st.out_free     = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg   <= in_ch.entity_key[KW-1:0];
            now_reg   <= in_ch.now_ms;
            known_reg <= in_ch.tgt_known;
            on_reg    <= in_ch.tgt_on;
        end
        if (ev & ~ev_used & ~have_free_reg)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        if (ev & ev_used & ~ev_match & (~have_old_reg | (rd_time < old_time_reg)))
        begin
            old_time_reg <= rd_time;
            old_idx_reg  <= eval_idx_reg;
        end
        if (ev_match)
        begin
            hit_idx_reg   <= eval_idx_reg;
            hit_time_reg  <= rd_time;
            hit_known_reg <= rd_known;
            hit_on_reg    <= rd_on;
        end
        if (rd_en)
        begin
            eval_idx_reg <= issue_reg[IW-1:0];
        end
        if (cmd.emit)
        begin
            out_allow_reg <= res_allow_reg;
            out_hit_reg   <= res_hit_reg;
            out_idx_reg   <= SLOT_IDX_W'(res_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg     <= '0;
            eval_vld_reg  <= 1'b0;
            have_free_reg <= 1'b0;
            have_old_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            used_reg      <= '0;
            res_allow_reg <= 1'b0;
            res_hit_reg   <= 1'b0;
            res_idx_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                issue_reg     <= '0;
                eval_vld_reg  <= 1'b0;
                have_free_reg <= 1'b0;
                have_old_reg  <= 1'b0;
                hit_reg       <= 1'b0;
                res_allow_reg <= 1'b0;
                res_hit_reg   <= 1'b0;
                res_idx_reg   <= '0;
            end
            else if (cmd.scan)
            begin
                eval_vld_reg <= rd_en;
                if (rd_en)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                if (ev & ~ev_used)
                begin
                    have_free_reg <= 1'b1;
                end
                if (ev & ev_used & ~ev_match)
                begin
                    have_old_reg <= 1'b1;
                end
                if (ev_match)
                begin
                    hit_reg <= 1'b1;
                end
            end
            else if (cmd.check)
            begin
                res_hit_reg <= 1'b1;
                res_idx_reg <= hit_idx_reg;
            end
            else if (cmd.write)
            begin
                used_reg[wr_addr] <= 1'b1;
                res_allow_reg     <= 1'b1;
                res_hit_reg       <= hit_reg;
                res_idx_reg       <= wr_addr;
            end

            if (cmd.emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid      = out_vld_reg;
    assign out_ch.allow      = out_allow_reg;
    assign out_ch.hit        = out_hit_reg;
    assign out_ch.slot_index = out_idx_reg;

endmodule
